>>> hdl/bidirectional_flow_table_defines.svh
// Assertion macros used by the checker file of the flow table.
`ifndef BIDIRECTIONAL_FLOW_TABLE_DEFINES_SVH
`define BIDIRECTIONAL_FLOW_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bft_pkg.sv
`default_nettype none

package bft_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  typedef enum logic [2:0] {
    ST_NOT_IPV4    = 3'd0,
    ST_OTHER_PROTO = 3'd1,
    ST_MATCHED     = 3'd2,
    ST_INSERTED    = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [16:0] frame_length;
    logic [31:0] now_seconds;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  entry_index;
    logic [31:0] entry_packets;
    logic [47:0] entry_bytes;
  } out_t;

  // One request travelling down the row of cells.
  typedef struct packed {
    logic        done;
    logic        udp;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [16:0] frame_length;
    logic [31:0] now_seconds;
    out_t        res;
  } stage_t;

endpackage

`default_nettype wire

>>> hdl/bft_cell.sv
`default_nettype none

module bft_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic [CNT_W-1:0]    entry_count,
  input  wire logic                in_vld,
  input  wire bft_pkg::stage_t     in_stage,
  output logic                     out_vld,
  output bft_pkg::stage_t          out_stage,
  output logic                     ins
);

  logic            vld_r;
  bft_pkg::stage_t stage_r;
  bft_pkg::stage_t stage_nxt;

  logic [31:0] src_addr_r;
  logic [31:0] dst_addr_r;
  logic [15:0] src_port_r;
  logic [15:0] dst_port_r;
  logic        is_udp_r;
  logic [31:0] packets_r;
  logic [47:0] bytes_r;
  logic [31:0] first_seen_r;
  logic [31:0] last_seen_r;

  logic        live;
  logic        occupied;
  logic        fwd;
  logic        rev;
  logic        match;
  logic [31:0] packets_nxt;
  logic [48:0] byte_sum;
  logic [47:0] bytes_nxt;

  always_comb begin
    live     = in_vld && !in_stage.done;
    occupied = CNT_W'(CELL_IDX) < entry_count;
    fwd = src_addr_r == in_stage.source_address &&
          dst_addr_r == in_stage.destination_address &&
          src_port_r == in_stage.source_port &&
          dst_port_r == in_stage.destination_port;
    rev = src_addr_r == in_stage.destination_address &&
          dst_addr_r == in_stage.source_address &&
          src_port_r == in_stage.destination_port &&
          dst_port_r == in_stage.source_port;
    match = live && occupied && (is_udp_r == in_stage.udp) && (fwd || rev);
    ins   = live && (entry_count == CNT_W'(CELL_IDX));

    packets_nxt = (packets_r == '1) ? packets_r : packets_r + 32'd1;
    byte_sum    = {1'b0, bytes_r} + {32'b0, in_stage.frame_length};
    bytes_nxt   = byte_sum[48] ? '1 : byte_sum[47:0];

    stage_nxt = in_stage;
    if (match) begin
      stage_nxt.done              = 1'b1;
      stage_nxt.res.status        = bft_pkg::ST_MATCHED;
      stage_nxt.res.entry_index   = 10'(CELL_IDX);
      stage_nxt.res.entry_packets = packets_nxt;
      stage_nxt.res.entry_bytes   = bytes_nxt;
    end else if (ins) begin
      stage_nxt.done              = 1'b1;
      stage_nxt.res.status        = bft_pkg::ST_INSERTED;
      stage_nxt.res.entry_index   = 10'(CELL_IDX);
      stage_nxt.res.entry_packets = 32'd1;
      stage_nxt.res.entry_bytes   = {31'b0, in_stage.frame_length};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
      if (match) begin
        packets_r   <= packets_nxt;
        bytes_r     <= bytes_nxt;
        last_seen_r <= in_stage.now_seconds;
      end else if (ins) begin
        src_addr_r   <= in_stage.source_address;
        dst_addr_r   <= in_stage.destination_address;
        src_port_r   <= in_stage.source_port;
        dst_port_r   <= in_stage.destination_port;
        is_udp_r     <= in_stage.udp;
        packets_r    <= 32'd1;
        bytes_r      <= {31'b0, in_stage.frame_length};
        first_seen_r <= in_stage.now_seconds;
        last_seen_r  <= in_stage.now_seconds;
      end
    end
  end

  assign out_vld   = vld_r;
  assign out_stage = stage_r;

endmodule

`default_nettype wire

>>> hdl/bidirectional_flow_table.sv
// Channel   Ports                          Carries
// in        in_valid, in_ready, in_data    one packet header summary
// out       out_valid, out_ready, out_data status, slot and counts
//
// Every request walks the whole row of cells, one cell per cycle while the
// row advances, and its result is then registered at the output.
// A new request can enter in every cycle while in_ready is high; results
// leave in request order. A stalled result freezes the row once the next
// result reaches the last cell, and in_ready falls with it.
// Reset empties the table at once; no clearing pass is needed.
`default_nettype none

module bidirectional_flow_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bft_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bft_pkg::out_t      out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic                 adv;
  logic                 out_free;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  bft_pkg::out_t        out_data_r;
  bft_pkg::stage_t      head;
  logic                 vld_chain   [0:TABLE_DEPTH];
  bft_pkg::stage_t      stage_chain [0:TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ins;

  assign out_free = !out_valid_r || out_ready;
  assign adv      = out_free || !vld_chain[TABLE_DEPTH];

  always_comb begin
    head.done                = 1'b1;
    head.udp                 = in_data.ip_protocol == bft_pkg::PROTO_UDP;
    head.source_address      = in_data.source_address;
    head.destination_address = in_data.destination_address;
    head.source_port         = in_data.source_port;
    head.destination_port    = in_data.destination_port;
    head.frame_length        = in_data.frame_length;
    head.now_seconds         = in_data.now_seconds;
    head.res.entry_index     = '0;
    head.res.entry_packets   = '0;
    head.res.entry_bytes     = '0;
    if (in_data.ether_type != bft_pkg::ETHERTYPE_IPV4) begin
      head.res.status = bft_pkg::ST_NOT_IPV4;
    end else if (in_data.ip_protocol != bft_pkg::PROTO_TCP &&
                 in_data.ip_protocol != bft_pkg::PROTO_UDP) begin
      head.res.status = bft_pkg::ST_OTHER_PROTO;
    end else begin
      head.done       = 1'b0;
      head.res.status = bft_pkg::ST_FULL;
    end
  end

  assign vld_chain[0]   = in_valid;
  assign stage_chain[0] = head;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    bft_cell #(
      .CELL_IDX (g),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .entry_count (count_r),
      .in_vld      (vld_chain[g]),
      .in_stage    (stage_chain[g]),
      .out_vld     (vld_chain[g+1]),
      .out_stage   (stage_chain[g+1]),
      .ins         (ins[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (adv && (|ins)) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_free) begin
        out_valid_r <= vld_chain[TABLE_DEPTH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= stage_chain[TABLE_DEPTH].res;
    end
  end

  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> hdl/bft_checker.sv
`default_nettype none
`include "bidirectional_flow_table_defines.svh"

module bft_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire bft_pkg::out_t out_data
);

  `BFT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `BFT_ASSERT_NOW(a_drop_zero, clk, rst_n, out_valid && (out_data.status == bft_pkg::ST_NOT_IPV4 || out_data.status == bft_pkg::ST_OTHER_PROTO || out_data.status == bft_pkg::ST_FULL), out_data.entry_index == 10'd0 && out_data.entry_packets == 32'd0 && out_data.entry_bytes == 48'd0, "unmatched result has nonzero fields")
  `BFT_ASSERT_NOW(a_insert_one, clk, rst_n, out_valid && out_data.status == bft_pkg::ST_INSERTED, out_data.entry_packets == 32'd1 && out_data.entry_bytes[47:17] == 31'd0, "new entry counts are wrong")
  `BFT_ASSERT_NOW(a_match_count, clk, rst_n, out_valid && out_data.status == bft_pkg::ST_MATCHED, out_data.entry_packets != 32'd0 && out_data.entry_packets != 32'd1, "matched entry has too few packets")

endmodule

bind bidirectional_flow_table bft_checker u_bft_checker (.*);

`default_nettype wire
